[src/qcos_pkg.sv]
package qcos_pkg;

   localparam int NUM_CORNERS = 4;
   localparam int TOP_COUNT   = 2;
   localparam int DIM_W       = 13;

   typedef logic [1:0]       rank_type;
   typedef logic [DIM_W-1:0] dim_type;

   localparam dim_type DIM_MAX = '1;

endpackage

[src/quad_corner_order_and_size_core.sv]
// start reaches rsp_strobe through the order stages, the edge stages, the root stages and the output register
// throughput: one beat per cycle, busy stays low, no stalls on either side
// depth is set by the edge-length square root, one root bit per pipeline stage
// reset clears every valid bit in the pipeline, payload registers are not reset
// results are always taken, one strobe per accepted beat
module quad_corner_order_and_size_core #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [COORD_BITS-1:0]   req_in_x0,
   input  logic [COORD_BITS-1:0]   req_in_y0,
   input  logic [COORD_BITS-1:0]   req_in_x1,
   input  logic [COORD_BITS-1:0]   req_in_y1,
   input  logic [COORD_BITS-1:0]   req_in_x2,
   input  logic [COORD_BITS-1:0]   req_in_y2,
   input  logic [COORD_BITS-1:0]   req_in_x3,
   input  logic [COORD_BITS-1:0]   req_in_y3,
   input  logic [COORD_BITS-1:0]   req_center_y,
   output logic                    rsp_strobe,
   output logic [COORD_BITS-1:0]   rsp_out_x0,
   output logic [COORD_BITS-1:0]   rsp_out_y0,
   output logic [COORD_BITS-1:0]   rsp_out_x1,
   output logic [COORD_BITS-1:0]   rsp_out_y1,
   output logic [COORD_BITS-1:0]   rsp_out_x2,
   output logic [COORD_BITS-1:0]   rsp_out_y2,
   output logic [COORD_BITS-1:0]   rsp_out_x3,
   output logic [COORD_BITS-1:0]   rsp_out_y3,
   output logic                    rsp_ordered_ok,
   output qcos_pkg::dim_type       rsp_dst_width,
   output qcos_pkg::dim_type       rsp_dst_height
);
   import qcos_pkg::*;

   localparam int CB     = COORD_BITS;
   localparam int SUM_W  = 2 * CB + 1;
   localparam int ROOT_W = CB + 1;
   localparam int XY_W   = NUM_CORNERS * CB;
   localparam int SIDE_W = 2 * XY_W + 1;
   localparam int DLY    = 3 + ROOT_W;
   localparam int LEN_W  = ROOT_W + DIM_W;
   localparam int NUM_EDGES = 4;

   // edge endpoints: width 0-1, 2-3; height 0-3, 1-2
   localparam int EA [NUM_EDGES] = '{0, 2, 0, 1};
   localparam int EB [NUM_EDGES] = '{1, 3, 3, 2};

   logic                            accept;
   logic [NUM_CORNERS-1:0][CB-1:0]  in_x, in_y;
   logic                            ord_vld, ord_ok;
   logic [NUM_CORNERS-1:0][CB-1:0]  ord_x, ord_y;
   logic [NUM_EDGES-1:0]            edge_vld, sq_vld;
   logic [SUM_W-1:0]                edge_sum [NUM_EDGES];
   logic [ROOT_W-1:0]               sq_root  [NUM_EDGES];
   logic [SIDE_W-1:0]               side_in;
   logic [SIDE_W-1:0]               side_ff [DLY];
   logic [LEN_W-1:0]                len_w    [NUM_EDGES];
   dim_type                         len      [NUM_EDGES];
   dim_type                         width_in, height_in, width_ff, height_ff;
   logic                            strobe_in, strobe_ff;
   logic [SIDE_W-1:0]               rsp_side_ff;
   logic [NUM_CORNERS-1:0][CB-1:0]  rsp_x, rsp_y;

   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign in_x   = {req_in_x3, req_in_x2, req_in_x1, req_in_x0};
   assign in_y   = {req_in_y3, req_in_y2, req_in_y1, req_in_y0};

   qcos_order #(.COORD_BITS(CB)) u_order (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (accept),
      .in_x    (in_x),
      .in_y    (in_y),
      .in_cy   (req_center_y),
      .out_vld (ord_vld),
      .out_x   (ord_x),
      .out_y   (ord_y),
      .out_ok  (ord_ok)
   );

   for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
      qcos_edge #(.COORD_BITS(CB)) u_edge (
         .clock   (clock),
         .reset   (reset),
         .in_vld  (ord_vld),
         .ax      (ord_x[EA[e]]),
         .ay      (ord_y[EA[e]]),
         .bx      (ord_x[EB[e]]),
         .by      (ord_y[EB[e]]),
         .out_vld (edge_vld[e]),
         .out_sum (edge_sum[e])
      );

      qcos_isqrt #(.IN_W(SUM_W)) u_isqrt (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (edge_vld[e]),
         .in_val   (edge_sum[e]),
         .out_vld  (sq_vld[e]),
         .out_root (sq_root[e])
      );
   end

   // ordered corners and flag ride alongside the edge lanes
   assign side_in = {ord_ok, ord_y, ord_x};

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int d = 1; d < DLY; d++) side_ff[d] <= side_ff[d-1];
   end

   // whole pixels, saturated, then larger of each pair
   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         len_w[e] = LEN_W'(sq_root[e]) >> FRAC_BITS;
         len[e]   = (len_w[e] > LEN_W'(DIM_MAX)) ? DIM_MAX : len_w[e][DIM_W-1:0];
      end
      width_in  = (len[0] > len[1]) ? len[0] : len[1];
      height_in = (len[2] > len[3]) ? len[2] : len[3];
      strobe_in = &sq_vld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_side_ff <= side_ff[DLY-1];
      width_ff    <= width_in;
      height_ff   <= height_in;
   end

   assign rsp_x = rsp_side_ff[XY_W-1:0];
   assign rsp_y = rsp_side_ff[2*XY_W-1:XY_W];

   assign rsp_strobe     = strobe_ff;
   assign rsp_out_x0     = rsp_x[0];
   assign rsp_out_y0     = rsp_y[0];
   assign rsp_out_x1     = rsp_x[1];
   assign rsp_out_y1     = rsp_y[1];
   assign rsp_out_x2     = rsp_x[2];
   assign rsp_out_y2     = rsp_y[2];
   assign rsp_out_x3     = rsp_x[3];
   assign rsp_out_y3     = rsp_y[3];
   assign rsp_ordered_ok = rsp_side_ff[SIDE_W-1];
   assign rsp_dst_width  = width_ff;
   assign rsp_dst_height = height_ff;

endmodule

[src/qcos_order.sv]
module qcos_order #(
   parameter int COORD_BITS = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_vld,
   input  logic [qcos_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] in_x,
   input  logic [qcos_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] in_y,
   input  logic [COORD_BITS-1:0]                           in_cy,
   output logic                                            out_vld,
   output logic [qcos_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] out_x,
   output logic [qcos_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] out_y,
   output logic                                            out_ok
);
   import qcos_pkg::*;

   // stage 1: stable rank by x, top eligibility
   logic                                    vld1_ff;
   logic [NUM_CORNERS-1:0][COORD_BITS-1:0]  x1_ff, y1_ff;
   rank_type                                rank1_in [NUM_CORNERS];
   rank_type                                rank1_ff [NUM_CORNERS];
   logic [NUM_CORNERS-1:0]                  elig1_in, elig1_ff;

   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         rank1_in[i] = '0;
         elig1_in[i] = $signed(in_y[i]) < $signed(in_cy);
         for (int j = 0; j < NUM_CORNERS; j++) begin
            if (j < i) begin
               if ($signed(in_x[j]) <= $signed(in_x[i])) rank1_in[i] = rank1_in[i] + 2'd1;
            end else if (j > i) begin
               if ($signed(in_x[j]) < $signed(in_x[i])) rank1_in[i] = rank1_in[i] + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff    <= in_x;
      y1_ff    <= in_y;
      rank1_ff <= rank1_in;
      elig1_ff <= elig1_in;
   end

   // stage 2: walk sorted order, split top and bottom, reorder
   logic                                    vld2_ff;
   logic [NUM_CORNERS-1:0][COORD_BITS-1:0]  x2_in, y2_in, x2_ff, y2_ff;
   logic                                    ok2_in, ok2_ff;
   rank_type                                srt [NUM_CORNERS];
   rank_type                                top_idx [NUM_CORNERS];
   rank_type                                bot_idx [NUM_CORNERS];
   rank_type                                ord [NUM_CORNERS];
   rank_type                                k;
   logic [2:0]                              nt, nb;

   always_comb begin
      for (int r = 0; r < NUM_CORNERS; r++) begin
         srt[r] = '0;
         for (int i = 0; i < NUM_CORNERS; i++) begin
            if (rank1_ff[i] == rank_type'(r)) srt[r] = rank_type'(i);
         end
      end
      for (int i = 0; i < NUM_CORNERS; i++) begin
         top_idx[i] = '0;
         bot_idx[i] = '0;
      end
      nt = '0;
      nb = '0;
      for (int r = 0; r < NUM_CORNERS; r++) begin
         k = srt[r];
         if (elig1_ff[k] && (nt < 3'(TOP_COUNT))) begin
            top_idx[nt[1:0]] = k;
            nt = nt + 3'd1;
         end else begin
            bot_idx[nb[1:0]] = k;
            nb = nb + 3'd1;
         end
      end
      ok2_in = (nt == 3'(TOP_COUNT));
      if (ok2_in) begin
         ord[0] = top_idx[0];
         ord[1] = top_idx[1];
         ord[2] = bot_idx[1];
         ord[3] = bot_idx[0];
      end else begin
         for (int i = 0; i < NUM_CORNERS; i++) ord[i] = rank_type'(i);
      end
      for (int i = 0; i < NUM_CORNERS; i++) begin
         x2_in[i] = x1_ff[ord[i]];
         y2_in[i] = y1_ff[ord[i]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      x2_ff  <= x2_in;
      y2_ff  <= y2_in;
      ok2_ff <= ok2_in;
   end

   assign out_vld = vld2_ff;
   assign out_x   = x2_ff;
   assign out_y   = y2_ff;
   assign out_ok  = ok2_ff;

endmodule

[src/qcos_edge.sv]
module qcos_edge #(
   parameter int COORD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  logic [COORD_BITS-1:0]   ax,
   input  logic [COORD_BITS-1:0]   ay,
   input  logic [COORD_BITS-1:0]   bx,
   input  logic [COORD_BITS-1:0]   by,
   output logic                    out_vld,
   output logic [2*COORD_BITS:0]   out_sum
);

   localparam int CB = COORD_BITS;

   logic [2:0]          vld_ff;
   logic [CB:0]         ddx, ddy, magx, magy;
   logic [CB-1:0]       dx_in, dy_in, dx_ff, dy_ff;
   logic [2*CB-1:0]     sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [2*CB:0]       sum_in, sum_ff;

   // absolute differences
   always_comb begin
      ddx   = {ax[CB-1], ax} - {bx[CB-1], bx};
      ddy   = {ay[CB-1], ay} - {by[CB-1], by};
      magx  = ddx[CB] ? (~ddx + 1'b1) : ddx;
      magy  = ddy[CB] ? (~ddy + 1'b1) : ddy;
      dx_in = magx[CB-1:0];
      dy_in = magy[CB-1:0];
   end

   assign sqx_in = (2*CB)'(dx_ff) * (2*CB)'(dx_ff);
   assign sqy_in = (2*CB)'(dy_ff) * (2*CB)'(dy_ff);
   assign sum_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      sum_ff <= sum_in;
   end

   assign out_vld = vld_ff[2];
   assign out_sum = sum_ff;

endmodule

[src/qcos_isqrt.sv]
module qcos_isqrt #(
   parameter int IN_W = 33
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  logic [IN_W-1:0]         in_val,
   output logic                    out_vld,
   output logic [(IN_W+1)/2-1:0]   out_root
);

   localparam int ROOT_W = (IN_W + 1) / 2;
   localparam int T_W    = IN_W + 1;

   logic [ROOT_W-1:0] vld_ff;
   logic [IN_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   // one root bit per stage, msb first
   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      localparam int K = ROOT_W - 1 - s;

      logic [IN_W-1:0]   rem_cur, rem_in;
      logic [ROOT_W-1:0] root_cur, root_in;
      logic              vld_cur;
      logic [T_W-1:0]    trial;

      if (s == 0) begin : g_first
         assign rem_cur  = in_val;
         assign root_cur = '0;
         assign vld_cur  = in_vld;
      end else begin : g_next
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
         assign vld_cur  = vld_ff[s-1];
      end

      assign trial = (T_W'(root_cur) << (K + 1)) + (T_W'(1) << (2 * K));

      always_comb begin
         if ({1'b0, rem_cur} >= trial) begin
            rem_in  = rem_cur - trial[IN_W-1:0];
            root_in = root_cur | (ROOT_W'(1) << K);
         end else begin
            rem_in  = rem_cur;
            root_in = root_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
      end
   end

   assign out_vld  = vld_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];

endmodule

[src/qcos_checker.sv]
module qcos_checker #(
   parameter int COORD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [COORD_BITS-1:0]   req_in_x0,
   input  logic [COORD_BITS-1:0]   req_in_y0,
   input  logic [COORD_BITS-1:0]   req_in_x1,
   input  logic [COORD_BITS-1:0]   req_in_y1,
   input  logic [COORD_BITS-1:0]   req_in_x2,
   input  logic [COORD_BITS-1:0]   req_in_y2,
   input  logic [COORD_BITS-1:0]   req_in_x3,
   input  logic [COORD_BITS-1:0]   req_in_y3,
   input  logic [COORD_BITS-1:0]   req_center_y,
   input  logic                    rsp_strobe,
   input  logic [COORD_BITS-1:0]   rsp_out_x0,
   input  logic [COORD_BITS-1:0]   rsp_out_y0,
   input  logic [COORD_BITS-1:0]   rsp_out_x1,
   input  logic [COORD_BITS-1:0]   rsp_out_y1,
   input  logic [COORD_BITS-1:0]   rsp_out_x2,
   input  logic [COORD_BITS-1:0]   rsp_out_y2,
   input  logic [COORD_BITS-1:0]   rsp_out_x3,
   input  logic [COORD_BITS-1:0]   rsp_out_y3,
   input  logic                    rsp_ordered_ok
);

   localparam int LAT = COORD_BITS + 7;

   // no beat comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("strobe right after reset");

   // each accepted beat returns after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("result missing at expected latency");

   // fallback passes the input corners through unchanged
   a_fallback: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ordered_ok) |->
         (rsp_out_x0 == $past(req_in_x0, LAT)) && (rsp_out_y0 == $past(req_in_y0, LAT)) &&
         (rsp_out_x1 == $past(req_in_x1, LAT)) && (rsp_out_y1 == $past(req_in_y1, LAT)) &&
         (rsp_out_x2 == $past(req_in_x2, LAT)) && (rsp_out_y2 == $past(req_in_y2, LAT)) &&
         (rsp_out_x3 == $past(req_in_x3, LAT)) && (rsp_out_y3 == $past(req_in_y3, LAT)))
      else $error("fallback corners differ from input");

   // ordered result: left before right, top corners above the center
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_ordered_ok) |->
         ($signed(rsp_out_x0) <= $signed(rsp_out_x1)) &&
         ($signed(rsp_out_x3) <= $signed(rsp_out_x2)) &&
         ($signed(rsp_out_y0) < $signed($past(req_center_y, LAT))) &&
         ($signed(rsp_out_y1) < $signed($past(req_center_y, LAT))))
      else $error("ordered corners inconsistent");

endmodule

bind quad_corner_order_and_size_core qcos_checker #(.COORD_BITS(COORD_BITS)) u_qcos_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int COORD_BITS  = 16;
   localparam int FRAC_BITS   = 4;
   localparam int RANDOM_QUADS = 1800;
   localparam int STUCK_LIMIT = 2000;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type x [4];
      coord_type y [4];
      coord_type cy;
   } quad_type;

   typedef struct {
      coord_type         x [4];
      coord_type         y [4];
      logic              ok;
      qcos_pkg::dim_type width;
      qcos_pkg::dim_type height;
   } corner_result_type;

   class corner_order_board;
      corner_result_type expected_q [$];
      int errors = 0;

      function longint unsigned floor_root(longint unsigned n);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function qcos_pkg::dim_type edge_pixels(coord_type ax, coord_type ay, coord_type bx,
                                              coord_type by);
         longint dx;
         longint dy;
         longint unsigned len;
         dx = longint'(ax) - longint'(bx);
         dy = longint'(ay) - longint'(by);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         len = floor_root(longint'(dx * dx) + longint'(dy * dy)) >> FRAC_BITS;
         if (len > longint'(qcos_pkg::DIM_MAX)) return qcos_pkg::DIM_MAX;
         return qcos_pkg::dim_type'(len);
      endfunction

      function corner_result_type order_and_size(quad_type q);
         int order [4];
         int top [2];
         int bottom [4];
         int sel [4];
         int nt;
         int nb;
         int k;
         int j;
         corner_result_type r;
         qcos_pkg::dim_type w1, w2, h1, h2;
         for (int i = 0; i < 4; i++) order[i] = i;
         // stable sort by x, equal x keeps input order
         for (int i = 1; i < 4; i++) begin
            k = order[i];
            j = i - 1;
            while (j >= 0 && q.x[k] < q.x[order[j]]) begin
               order[j+1] = order[j];
               j--;
            end
            order[j+1] = k;
         end
         nt = 0;
         nb = 0;
         for (int i = 0; i < 4; i++) begin
            k = order[i];
            if (q.y[k] < q.cy && nt < qcos_pkg::TOP_COUNT) begin
               top[nt] = k;
               nt++;
            end else begin
               bottom[nb] = k;
               nb++;
            end
         end
         r.ok = (nt == qcos_pkg::TOP_COUNT && nb == qcos_pkg::TOP_COUNT);
         if (r.ok) begin
            sel[0] = top[0];
            sel[1] = top[1];
            sel[2] = bottom[1];
            sel[3] = bottom[0];
         end else begin
            for (int i = 0; i < 4; i++) sel[i] = i;
         end
         for (int i = 0; i < 4; i++) begin
            r.x[i] = q.x[sel[i]];
            r.y[i] = q.y[sel[i]];
         end
         h1 = edge_pixels(r.x[0], r.y[0], r.x[3], r.y[3]);
         h2 = edge_pixels(r.x[1], r.y[1], r.x[2], r.y[2]);
         w1 = edge_pixels(r.x[0], r.y[0], r.x[1], r.y[1]);
         w2 = edge_pixels(r.x[2], r.y[2], r.x[3], r.y[3]);
         r.width  = (w1 > w2) ? w1 : w2;
         r.height = (h1 > h2) ? h1 : h2;
         return r;
      endfunction

      function void note_quad(quad_type q);
         expected_q.insert(expected_q.size(), order_and_size(q));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            $display("%0t ns mismatch %s: expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(corner_result_type got);
         corner_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t ns result beat with nothing pending", $time);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         for (int i = 0; i < 4; i++) begin
            compare_field($sformatf("out_x%0d", i), want.x[i], got.x[i]);
            compare_field($sformatf("out_y%0d", i), want.y[i], got.y[i]);
         end
         compare_field("ordered_ok", want.ok, got.ok);
         compare_field("dst_width", want.width, got.width);
         compare_field("dst_height", want.height, got.height);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   coord_type req_in_x0, req_in_y0, req_in_x1, req_in_y1;
   coord_type req_in_x2, req_in_y2, req_in_x3, req_in_y3;
   coord_type req_center_y;
   logic rsp_strobe;
   coord_type rsp_out_x0, rsp_out_y0, rsp_out_x1, rsp_out_y1;
   coord_type rsp_out_x2, rsp_out_y2, rsp_out_x3, rsp_out_y3;
   logic rsp_ordered_ok;
   qcos_pkg::dim_type rsp_dst_width;
   qcos_pkg::dim_type rsp_dst_height;

   corner_order_board board;
   corner_result_type observed_beat;
   int stuck_cycles = 0;

   quad_corner_order_and_size_core #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_in_x0     (req_in_x0),
      .req_in_y0     (req_in_y0),
      .req_in_x1     (req_in_x1),
      .req_in_y1     (req_in_y1),
      .req_in_x2     (req_in_x2),
      .req_in_y2     (req_in_y2),
      .req_in_x3     (req_in_x3),
      .req_in_y3     (req_in_y3),
      .req_center_y  (req_center_y),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_x0    (rsp_out_x0),
      .rsp_out_y0    (rsp_out_y0),
      .rsp_out_x1    (rsp_out_x1),
      .rsp_out_y1    (rsp_out_y1),
      .rsp_out_x2    (rsp_out_x2),
      .rsp_out_y2    (rsp_out_y2),
      .rsp_out_x3    (rsp_out_x3),
      .rsp_out_y3    (rsp_out_y3),
      .rsp_ordered_ok(rsp_ordered_ok),
      .rsp_dst_width (rsp_dst_width),
      .rsp_dst_height(rsp_dst_height)
   );

   always #4 clock = ~clock;

   function automatic quad_type quad_of(int x0, int y0, int x1, int y1, int x2, int y2,
                                        int x3, int y3, int cy);
      quad_type q;
      q.x[0] = coord_type'(x0);
      q.y[0] = coord_type'(y0);
      q.x[1] = coord_type'(x1);
      q.y[1] = coord_type'(y1);
      q.x[2] = coord_type'(x2);
      q.y[2] = coord_type'(y2);
      q.x[3] = coord_type'(x3);
      q.y[3] = coord_type'(y3);
      q.cy   = coord_type'(cy);
      return q;
   endfunction

   function automatic quad_type make_quad();
      quad_type q;
      int kind;
      int c;
      int j;
      coord_type tx;
      coord_type ty;
      kind = $urandom_range(99);
      if (kind < 25) begin
         for (int i = 0; i < 4; i++) begin
            q.x[i] = coord_type'($urandom);
            q.y[i] = coord_type'($urandom);
         end
         q.cy = coord_type'($urandom);
         return q;
      end
      // two corners above the center and two at or below it
      c = int'($urandom_range(65535, 1)) - 32768;
      q.cy = coord_type'(c);
      for (int i = 0; i < 4; i++) begin
         if (i < 2) q.y[i] = coord_type'(int'($urandom_range(c + 32767, 0)) - 32768);
         else if (kind < 55 && $urandom_range(1) == 1) q.y[i] = coord_type'(c);
         else q.y[i] = coord_type'(int'($urandom_range(65535, c + 32768)) - 32768);
         if (kind < 45) q.x[i] = coord_type'(int'($urandom_range(3)) * 16 - 24);
         else q.x[i] = coord_type'($urandom);
      end
      for (int i = 3; i > 0; i--) begin
         j = $urandom_range(i);
         tx = q.x[i];
         ty = q.y[i];
         q.x[i] = q.x[j];
         q.y[i] = q.y[j];
         q.x[j] = tx;
         q.y[j] = ty;
      end
      return q;
   endfunction

   task automatic send_quad(quad_type q);
      @(negedge clock);
      start        <= 1'b1;
      req_in_x0    <= q.x[0];
      req_in_y0    <= q.y[0];
      req_in_x1    <= q.x[1];
      req_in_y1    <= q.y[1];
      req_in_x2    <= q.x[2];
      req_in_y2    <= q.y[2];
      req_in_x3    <= q.x[3];
      req_in_y3    <= q.y[3];
      req_center_y <= q.cy;
      do @(posedge clock); while (busy);
      board.note_quad(q);
   endtask

   task automatic idle_for(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start        <= 1'b0;
         req_in_x0    <= coord_type'($urandom);
         req_in_y2    <= coord_type'($urandom);
         req_center_y <= coord_type'($urandom);
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         observed_beat.x[0]   = rsp_out_x0;
         observed_beat.y[0]   = rsp_out_y0;
         observed_beat.x[1]   = rsp_out_x1;
         observed_beat.y[1]   = rsp_out_y1;
         observed_beat.x[2]   = rsp_out_x2;
         observed_beat.y[2]   = rsp_out_y2;
         observed_beat.x[3]   = rsp_out_x3;
         observed_beat.y[3]   = rsp_out_y3;
         observed_beat.ok     = rsp_ordered_ok;
         observed_beat.width  = rsp_dst_width;
         observed_beat.height = rsp_dst_height;
         board.check_result(observed_beat);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      board        = new();
      reset        = 1'b1;
      start        = 1'b0;
      req_in_x0    = '0;
      req_in_y0    = '0;
      req_in_x1    = '0;
      req_in_y1    = '0;
      req_in_x2    = '0;
      req_in_y2    = '0;
      req_in_x3    = '0;
      req_in_y3    = '0;
      req_center_y = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_quad(quad_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_quad(quad_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_quad(quad_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                        -32768));
      send_quad(quad_of(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768, 0));
      send_quad(quad_of(0, 0, 160, 0, 160, 160, 0, 160, 80));
      send_quad(quad_of(0, 160, 160, 160, 160, 0, 0, 0, 80));
      // equal x everywhere
      send_quad(quad_of(100, 0, 100, 50, 100, 200, 100, 300, 100));
      send_quad(quad_of(10, 300, 10, 0, 50, 300, 50, 0, 100));
      // corners on the center line go to the bottom
      send_quad(quad_of(0, 100, 100, 100, 100, 0, 0, 0, 100));
      send_quad(quad_of(0, 100, 100, 100, 200, 100, 300, 100, 100));
      send_quad(quad_of(0, 0, 10, 0, 20, 0, 30, 500, 100));
      // fallback, too few corners above
      send_quad(quad_of(0, 0, 10, 500, 20, 500, 30, 500, 100));
      send_quad(quad_of(-32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768,
                        -32768));
      send_quad(quad_of(40, 1, 10, 2, 30, 3, 20, 4, 32767));
      send_quad(quad_of(5, 5, 5, 5, 5, 5, 5, 5, 6));
      send_quad(quad_of(0, 0, 15, 0, 15, 15, 0, 15, 8));
      send_quad(quad_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0));
      send_quad(quad_of(-400, -400, -200, -410, -190, -150, -410, -160, -280));
      send_quad(quad_of(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846, 0));
      send_quad(quad_of(-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845, -1));

      for (int n = 0; n < RANDOM_QUADS; n++) begin
         if (n == 1300) wait_for_drain();
         else if (!(n >= 700 && n < 1000) && $urandom_range(99) < 34)
            idle_for($urandom_range(2, 1));
         send_quad(make_quad());
      end
      @(negedge clock);
      start <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
